// ===== sv/sgm_pkg.sv =====
// shared types and constants of the stereo gain, mix and peak meter
package sgm_pkg;

  // default sample and gain formats
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int GAIN_FRAC_BITS_DEF = 12;

  // fixed field widths
  localparam int GAIN_BITS     = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // register reset values
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STEREO_MODE   = 2'd0,
    REG_GAIN_LEFT     = 2'd1,
    REG_GAIN_RIGHT    = 2'd2,
    REG_METER_ENABLED = 2'd3
  } cfg_reg_t;

  // control of the peak tracker for one frame
  typedef struct packed {
    logic step;    // frame moves into the result register
    logic track;   // scaled samples take part in the peak
    logic stereo;  // two channels per frame
    logic last;    // last frame of a buffer
    logic meter;   // peaks are reported
  } peak_ctrl_t;

endpackage

// ===== sv/sgm_lane.sv =====
// one channel lane: gain scaling with saturation, then mix and clamp
module sgm_lane #(
  parameter int SAMPLE_BITS    = sgm_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = sgm_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic        [sgm_pkg::GAIN_BITS-1:0] gain,
  input  logic                              mix_en,
  input  logic signed [SAMPLE_BITS-1:0]     second,
  output logic signed [SAMPLE_BITS-1:0]     scaled,
  output logic signed [SAMPLE_BITS-1:0]     mixed
);
  import sgm_pkg::*;

  localparam int PROD_BITS  = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int SHIFT_BITS = PROD_BITS - GAIN_FRAC_BITS;
  localparam int SUM_BITS   = SAMPLE_BITS + 1;
  localparam logic signed [SUM_BITS-1:0] ONE_Q     = SUM_BITS'(1) << (SAMPLE_BITS - 4);
  localparam logic signed [SUM_BITS-1:0] NEG_ONE_Q = -ONE_Q;

  logic signed [GAIN_BITS:0]      gain_s;
  logic signed [PROD_BITS-1:0]    prod;
  logic signed [SHIFT_BITS-1:0]   shifted;
  logic                           fits;
  logic signed [SUM_BITS-1:0]     sum;

  // signed sample times unsigned gain
  assign gain_s = {1'b0, gain};
  assign prod   = sample * gain_s;

  // drop the fraction bits, rounding toward minus infinity
  assign shifted = prod[PROD_BITS-1:GAIN_FRAC_BITS];

  // saturate to the sample range
  assign fits = (&shifted[SHIFT_BITS-1:SAMPLE_BITS-1]) |
                (~|shifted[SHIFT_BITS-1:SAMPLE_BITS-1]);
  assign scaled = fits ? shifted[SAMPLE_BITS-1:0]
                       : {shifted[SHIFT_BITS-1], {(SAMPLE_BITS-1){~shifted[SHIFT_BITS-1]}}};

  // optional mix with the second source
  assign sum = mix_en ? SUM_BITS'(scaled) + SUM_BITS'(second) : SUM_BITS'(scaled);

  // clamp to plus or minus one
  always_comb begin
    if (sum > ONE_Q) begin
      mixed = ONE_Q[SAMPLE_BITS-1:0];
    end else if (sum < NEG_ONE_Q) begin
      mixed = NEG_ONE_Q[SAMPLE_BITS-1:0];
    end else begin
      mixed = sum[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== sv/sgm_peak.sv =====
// running positive peak per channel, reported and cleared at buffer end
module sgm_peak #(
  parameter int SAMPLE_BITS = sgm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sgm_pkg::peak_ctrl_t           ctrl,
  input  logic signed [SAMPLE_BITS-1:0] scaled_left,
  input  logic signed [SAMPLE_BITS-1:0] scaled_right,
  output logic        [SAMPLE_BITS-2:0] peak_left,
  output logic        [SAMPLE_BITS-2:0] peak_right
);
  import sgm_pkg::*;

  logic [SAMPLE_BITS-2:0] running_peak_left;
  logic [SAMPLE_BITS-2:0] running_peak_right;
  logic [SAMPLE_BITS-2:0] running_peak_left_next;
  logic [SAMPLE_BITS-2:0] running_peak_right_next;
  logic [SAMPLE_BITS-2:0] upd_left;
  logic [SAMPLE_BITS-2:0] upd_right;
  logic                   gt_left;
  logic                   gt_right;

  // strictly greater, negative samples never win
  assign gt_left  = !scaled_left[SAMPLE_BITS-1] &&
                    (scaled_left[SAMPLE_BITS-2:0] > running_peak_left);
  assign gt_right = !scaled_right[SAMPLE_BITS-1] &&
                    (scaled_right[SAMPLE_BITS-2:0] > running_peak_right);

  // peaks including this frame; in mono the left sample drives both
  always_comb begin
    upd_left  = running_peak_left;
    upd_right = running_peak_right;
    if (ctrl.track) begin
      if (ctrl.stereo) begin
        if (gt_left) begin
          upd_left = scaled_left[SAMPLE_BITS-2:0];
        end
        if (gt_right) begin
          upd_right = scaled_right[SAMPLE_BITS-2:0];
        end
      end else if (gt_left) begin
        upd_left  = scaled_left[SAMPLE_BITS-2:0];
        upd_right = scaled_left[SAMPLE_BITS-2:0];
      end
    end
  end

  // report on the buffer's last frame, with metering on
  assign peak_left  = (ctrl.last && ctrl.meter) ? upd_left  : '0;
  assign peak_right = (ctrl.last && ctrl.meter) ? upd_right : '0;

  // clear at buffer end
  assign running_peak_left_next  = ctrl.last ? '0 : upd_left;
  assign running_peak_right_next = ctrl.last ? '0 : upd_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak_left  <= '0;
      running_peak_right <= '0;
    end else if (ctrl.step) begin
      running_peak_left  <= running_peak_left_next;
      running_peak_right <= running_peak_right_next;
    end
  end

endmodule

// ===== sv/stereo_gain_mix_peak_meter.sv =====
// top level: input register, two gain and mix lanes, peak tracker, result register
//
//  channel   | handshake                   | contents
//  ----------+-----------------------------+------------------------------------------
//  config    | cfg_we                      | cfg_index, cfg_data
//  s_axis    | s_axis_tvalid/s_axis_tready | primary and second samples, flag, last
//  m_axis    | m_axis_tvalid/m_axis_tready | mixed samples, peaks, peak valid, last
//
// one frame per cycle sustained while m_axis takes results; a frame reaches m_axis
// through the input register, which its transaction on s_axis loads, and then
// the result register
// the running peaks advance as a frame moves into the result register
// rst is synchronous, clears the pipeline and the peaks and resets the configuration registers
// a stall on m_axis holds the result; s_axis keeps taking a frame while the
// input register is empty or moving on
module stereo_gain_mix_peak_meter #(
  parameter int SAMPLE_BITS    = sgm_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = sgm_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [sgm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [sgm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // input frames
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // primary_left, primary_right, second_left, second_right
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // has_second
  input  logic                                  s_axis_tuser,
  input  logic                                  s_axis_tlast,
  // result frames
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out_left, out_right, peak_left, peak_right
  output logic [((4*SAMPLE_BITS+5)/8)*8-1:0]    m_axis_tdata,
  // peak_valid
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);
  import sgm_pkg::*;

  localparam int OUT_FIELD_W = 4*SAMPLE_BITS - 2;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam logic UNITY_OK  = GAIN_FRAC_BITS < GAIN_BITS;
  localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(1) << GAIN_FRAC_BITS;

  // configuration registers
  logic                 stereo_mode;
  logic [GAIN_BITS-1:0] gain_left;
  logic [GAIN_BITS-1:0] gain_right;
  logic                 meter_enabled;

  // input register
  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_pl;
  logic signed [SAMPLE_BITS-1:0] in_pr;
  logic signed [SAMPLE_BITS-1:0] in_sl;
  logic signed [SAMPLE_BITS-1:0] in_sr;
  logic                          in_second;
  logic                          in_last;

  // result register
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_user;
  logic                  out_last;

  // datapath
  logic                          out_ready;
  logic                          step;
  logic                          bypass;
  logic signed [SAMPLE_BITS-1:0] scaled_l;
  logic signed [SAMPLE_BITS-1:0] scaled_r;
  logic signed [SAMPLE_BITS-1:0] mixed_l;
  logic signed [SAMPLE_BITS-1:0] mixed_r;
  logic signed [SAMPLE_BITS-1:0] res_l;
  logic signed [SAMPLE_BITS-1:0] res_r;
  logic        [SAMPLE_BITS-2:0] pk_l;
  logic        [SAMPLE_BITS-2:0] pk_r;
  peak_ctrl_t                    pctrl;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode   <= 1'b1;
      gain_left     <= GAIN_RESET;
      gain_right    <= GAIN_RESET;
      meter_enabled <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEREO_MODE:   stereo_mode   <= cfg_data[0];
        REG_GAIN_LEFT:     gain_left     <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_RIGHT:    gain_right    <= cfg_data[GAIN_BITS-1:0];
        REG_METER_ENABLED: meter_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign out_ready     = !out_valid || m_axis_tready;
  assign step          = in_valid && out_ready;
  assign s_axis_tready = !in_valid || out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_pl     <= s_axis_tdata[SAMPLE_BITS-1:0];
      in_pr     <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      in_sl     <= s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      in_sr     <= s_axis_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
      in_second <= s_axis_tuser;
      in_last   <= s_axis_tlast;
    end
  end

  // gain and mix lanes
  sgm_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_left (
    .sample (in_pl),
    .gain   (gain_left),
    .mix_en (in_second),
    .second (in_sl),
    .scaled (scaled_l),
    .mixed  (mixed_l)
  );

  sgm_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_right (
    .sample (in_pr),
    .gain   (gain_right),
    .mix_en (in_second),
    .second (in_sr),
    .scaled (scaled_r),
    .mixed  (mixed_r)
  );

  // unity pass-through with metering off and nothing to mix
  assign bypass = !in_second && !meter_enabled && UNITY_OK &&
                  (gain_left == UNITY) && (gain_right == UNITY);

  assign res_l = bypass ? in_pl : mixed_l;
  assign res_r = !stereo_mode ? '0 : (bypass ? in_pr : mixed_r);

  // peak tracker
  assign pctrl.step   = step;
  assign pctrl.track  = !bypass;
  assign pctrl.stereo = stereo_mode;
  assign pctrl.last   = in_last;
  assign pctrl.meter  = meter_enabled;

  sgm_peak #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_peak (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (pctrl),
    .scaled_left  (scaled_l),
    .scaled_right (scaled_r),
    .peak_left    (pk_l),
    .peak_right   (pk_r)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= OUT_DATA_W'({pk_r, pk_l, res_r, res_l});
      out_user <= in_last && meter_enabled;
      out_last <= in_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;
  assign m_axis_tlast  = out_last;

endmodule

// ===== sv/sgm_checker.sv =====
// port checker for the result stream, bound to the top level
module sgm_checker #(
  parameter int SAMPLE_BITS = sgm_pkg::SAMPLE_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((4*SAMPLE_BITS+5)/8)*8-1:0]   m_axis_tdata,
  input logic                                 m_axis_tuser,
  input logic                                 m_axis_tlast
);
  import sgm_pkg::*;

  localparam int PEAK_LO = 2*SAMPLE_BITS;
  localparam int PEAK_HI = 4*SAMPLE_BITS - 3;

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // peaks are reported only at buffer end
  a_peak_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("peak report without buffer end");

  // peak fields read zero without a report
  a_peak_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[PEAK_HI:PEAK_LO] == '0)
    else $error("peak fields set without a report");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind stereo_gain_mix_peak_meter sgm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sgm_checker (.*);
